>>> hdl/bank_address_decoder_assert.svh
// assertion macros for the bank address decoder
`ifndef BANK_ADDRESS_DECODER_ASSERT_SVH
`define BANK_ADDRESS_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define BAD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bank decoder check failed");

`define BAD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bank decoder check failed");

`else

`define BAD_ASSERT_IMP(name, ante, cons)

`define BAD_ASSERT_NXT(name, ante, cons)

`endif

`endif

>>> hdl/bad_pkg.sv
// shared types and constants of the bank address decoder
package bad_pkg;

  localparam int BANK_BITS = 8;

  typedef enum logic [3:0] {
    REGION_UNMAPPED = 4'd0,
    REGION_CHIP     = 4'd1,
    REGION_FAST     = 4'd2,
    REGION_PERIPH   = 4'd3,
    REGION_SLOW     = 4'd4,
    REGION_CLOCK    = 4'd5,
    REGION_CUSTOM   = 4'd6,
    REGION_BOOT     = 4'd7,
    REGION_KICK     = 4'd8
  } region_t;

  typedef enum logic [2:0] {
    CFG_CHIP_BANKS    = 3'd0,
    CFG_FAST_BANKS    = 3'd1,
    CFG_SLOW_BANKS    = 3'd2,
    CFG_CLOCK_ENABLED = 3'd3,
    CFG_OVERLAY_ON    = 3'd4,
    CFG_BOOT_PRESENT  = 3'd5,
    CFG_KICK_PRESENT  = 3'd6,
    CFG_KICK_WRITABLE = 3'd7
  } cfg_index_t;

  localparam logic [BANK_BITS-1:0] BANK_FAST_FIRST   = 8'h20;
  localparam logic [BANK_BITS-1:0] BANK_PERIPH_FIRST = 8'hA0;
  localparam logic [BANK_BITS-1:0] BANK_PERIPH_LAST  = 8'hBF;
  localparam logic [BANK_BITS-1:0] BANK_CUSTOM_FIRST = 8'hC0;
  localparam logic [BANK_BITS-1:0] BANK_CUSTOM_LAST  = 8'hDF;
  localparam logic [BANK_BITS-1:0] BANK_CLOCK_FIRST  = 8'hDC;
  localparam logic [BANK_BITS-1:0] BANK_CLOCK_LAST   = 8'hDE;
  localparam logic [BANK_BITS-1:0] BANK_BOOT_FIRST   = 8'hF8;
  localparam logic [BANK_BITS-1:0] BANK_KICK_FIRST   = 8'hFC;
  localparam logic [7:0]           FAST_MAX_BANKS    = 8'd128;
  localparam logic [3:0]           SLOW_MAX_BANKS    = 4'd8;
  localparam logic [22:0]          FAST_BASE         = 23'h200000;

  typedef struct packed {
    logic [5:0] chip_banks;
    logic [7:0] fast_banks;
    logic [3:0] slow_banks;
    logic       clock_enabled;
    logic       overlay_on;
    logic       boot_present;
    logic       kick_present;
    logic       kick_writable;
  } cfg_t;

  typedef struct packed {
    logic [23:0] address;
    logic        is_write;
    logic        is_word;
    logic [15:0] data_in;
  } in_word_t;

  typedef struct packed {
    region_t     region;
    logic [22:0] offset;
    logic        forward_write;
    logic        constant_read;
    logic        constant_value;
    logic        periph_a_select;
    logic        periph_b_select;
    logic [3:0]  periph_register;
    logic [7:0]  custom_word_index;
    logic [15:0] data_out;
  } out_word_t;

  // classified access waiting between front and back
  typedef struct packed {
    region_t  region;
    in_word_t word;
  } item_t;

endpackage

>>> hdl/bad_front.sv
// front end: classifies the bank of each accepted word into a region
module bad_front (
  input  logic              in_valid,
  input  bad_pkg::in_word_t in_word,
  input  bad_pkg::cfg_t     cfg,
  output logic              push_valid,
  output bad_pkg::item_t    push_item
);

  logic [bad_pkg::BANK_BITS-1:0] bank;
  logic [bad_pkg::BANK_BITS:0]   fast_limit;
  logic [7:0]                    fast_cap;
  logic [3:0]                    slow_cap;
  logic [bad_pkg::BANK_BITS-1:0] slow_limit;
  bad_pkg::region_t              kick_map;
  bad_pkg::region_t              boot_map;
  bad_pkg::region_t              low_rom_map;
  bad_pkg::region_t              base_map;
  bad_pkg::region_t              region;
  logic                          low_rom_unmapped;

  assign bank = in_word.address[23:16];

  always_comb begin
    fast_cap   = (cfg.fast_banks > bad_pkg::FAST_MAX_BANKS) ?
                 bad_pkg::FAST_MAX_BANKS : cfg.fast_banks;
    slow_cap   = (cfg.slow_banks > bad_pkg::SLOW_MAX_BANKS) ?
                 bad_pkg::SLOW_MAX_BANKS : cfg.slow_banks;
    fast_limit = {1'b0, bad_pkg::BANK_FAST_FIRST} + {1'b0, fast_cap};
    slow_limit = bad_pkg::BANK_CUSTOM_FIRST + {4'd0, slow_cap};
    kick_map   = cfg.kick_present ? bad_pkg::REGION_KICK : bad_pkg::REGION_UNMAPPED;
    boot_map   = cfg.boot_present ? bad_pkg::REGION_BOOT : bad_pkg::REGION_UNMAPPED;
    low_rom_map = cfg.kick_writable ? boot_map : kick_map;
    low_rom_unmapped = (low_rom_map == bad_pkg::REGION_UNMAPPED);

    priority if (bank < bad_pkg::BANK_FAST_FIRST) begin
      base_map = bad_pkg::REGION_CHIP;
    end else if ({1'b0, bank} < fast_limit) begin
      base_map = bad_pkg::REGION_FAST;
    end else if (bank >= bad_pkg::BANK_PERIPH_FIRST && bank <= bad_pkg::BANK_PERIPH_LAST) begin
      base_map = bad_pkg::REGION_PERIPH;
    end else if (bank >= bad_pkg::BANK_CUSTOM_FIRST && bank <= bad_pkg::BANK_CUSTOM_LAST) begin
      if (bank < slow_limit) begin
        base_map = bad_pkg::REGION_SLOW;
      end else if (cfg.clock_enabled && bank >= bad_pkg::BANK_CLOCK_FIRST &&
                   bank <= bad_pkg::BANK_CLOCK_LAST) begin
        base_map = bad_pkg::REGION_CLOCK;
      end else begin
        base_map = bad_pkg::REGION_CUSTOM;
      end
    end else if (bank >= bad_pkg::BANK_BOOT_FIRST && bank < bad_pkg::BANK_KICK_FIRST) begin
      base_map = low_rom_map;
    end else if (bank >= bad_pkg::BANK_KICK_FIRST) begin
      base_map = kick_map;
    end else begin
      base_map = bad_pkg::REGION_UNMAPPED;
    end

    // overlay: banks 0-7 mirror the rom banks until the first unmapped one
    region = base_map;
    if (cfg.overlay_on && bank[7:3] == 5'd0) begin
      if (bank[2] == 1'b0) begin
        if (!low_rom_unmapped) begin
          region = low_rom_map;
        end
      end else if (!low_rom_unmapped && cfg.kick_present) begin
        region = bad_pkg::REGION_KICK;
      end
    end
  end

  assign push_valid       = in_valid;
  assign push_item.region = region;
  assign push_item.word   = in_word;

endmodule

>>> hdl/bad_queue.sv
// two-entry queue between the classifying front and the decoding back
module bad_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  bad_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bad_pkg::item_t head_item
);

  `include "bank_address_decoder_assert.svh"

  bad_pkg::item_t entries_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           push;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = entries_r[rd_ptr_r];
  assign push       = push_valid && !full;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  `BAD_ASSERT_IMP(a_pop_not_empty, pop, count_r != 2'd0)
  `BAD_ASSERT_NXT(a_fill_to_full, push && !pop && count_r == 2'd1, full)
  `BAD_ASSERT_IMP(a_ptrs_match_count, count_r == 2'd0 || count_r == 2'd2, wr_ptr_r == rd_ptr_r)

endmodule

>>> hdl/bad_back.sv
// back end: offset, selects, write forwarding, constant reads and the result register
module bad_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [5:0]         chip_banks,
  input  logic               head_valid,
  input  bad_pkg::item_t     head_item,
  output logic               pop,
  output logic               out_valid,
  output bad_pkg::out_word_t out_word,
  input  logic               out_stall
);

  `include "bank_address_decoder_assert.svh"

  logic               out_valid_r;
  logic               out_valid_nxt;
  bad_pkg::out_word_t out_word_r;
  bad_pkg::out_word_t out_word_nxt;
  logic [5:0]         chip_div;
  logic [5:0]         rem;
  logic [23:0]        addr;
  logic [15:0]        din;
  logic               forwarded;

  assign addr      = head_item.word.address;
  assign din       = head_item.word.data_in;
  assign chip_div  = (chip_banks == 6'd0) ? 6'd1 : chip_banks;
  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // chip mirror: bank number (below 32) modulo the chip size, bit by bit
  always_comb begin
    rem = 6'd0;
    for (int i = 4; i >= 0; i--) begin
      rem = {rem[4:0], addr[16+i]};
      if (rem >= chip_div) begin
        rem = rem - chip_div;
      end
    end
  end

  always_comb begin
    out_word_nxt        = '0;
    out_word_nxt.region = head_item.region;
    forwarded           = 1'b0;
    unique case (head_item.region)
      bad_pkg::REGION_CHIP: begin
        out_word_nxt.offset = {2'd0, rem[4:0], addr[15:0]};
        forwarded           = 1'b1;
      end
      bad_pkg::REGION_FAST: begin
        out_word_nxt.offset = addr[22:0] - bad_pkg::FAST_BASE;
        forwarded           = 1'b1;
      end
      bad_pkg::REGION_SLOW: begin
        out_word_nxt.offset = {4'd0, addr[18:0]};
        forwarded           = 1'b1;
      end
      bad_pkg::REGION_BOOT, bad_pkg::REGION_KICK: begin
        out_word_nxt.offset = {5'd0, addr[17:0]};
      end
      bad_pkg::REGION_PERIPH: begin
        out_word_nxt.periph_a_select = !addr[12];
        out_word_nxt.periph_b_select = !addr[13];
        out_word_nxt.periph_register = addr[11:8];
        forwarded                    = 1'b1;
      end
      bad_pkg::REGION_CUSTOM: begin
        out_word_nxt.custom_word_index = addr[8:1];
        forwarded                      = 1'b1;
      end
      default: begin
      end
    endcase

    if (head_item.word.is_write) begin
      out_word_nxt.forward_write = forwarded;
      if (forwarded) begin
        if (head_item.word.is_word) begin
          out_word_nxt.data_out = din;
        end else if (head_item.region == bad_pkg::REGION_CUSTOM) begin
          out_word_nxt.data_out = {din[7:0], din[7:0]};
        end else begin
          out_word_nxt.data_out = {8'd0, din[7:0]};
        end
      end
    end else if (head_item.region == bad_pkg::REGION_UNMAPPED ||
                 head_item.region == bad_pkg::REGION_CLOCK) begin
      out_word_nxt.constant_read  = 1'b1;
      out_word_nxt.constant_value = (head_item.region == bad_pkg::REGION_CLOCK) &&
                                    !head_item.word.is_word;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= out_word_nxt;
    end
  end

  `BAD_ASSERT_IMP(a_fwd_or_const, out_valid_r,
                  !(out_word_r.forward_write && out_word_r.constant_read))
  `BAD_ASSERT_IMP(a_const_value_clock, out_valid_r && out_word_r.constant_value,
                  out_word_r.constant_read && out_word_r.region == bad_pkg::REGION_CLOCK)
  `BAD_ASSERT_IMP(a_no_rom_write, out_valid_r && out_word_r.forward_write,
                  out_word_r.region != bad_pkg::REGION_BOOT &&
                  out_word_r.region != bad_pkg::REGION_KICK &&
                  out_word_r.region != bad_pkg::REGION_CLOCK &&
                  out_word_r.region != bad_pkg::REGION_UNMAPPED)

endmodule

>>> hdl/bank_address_decoder.sv
// bank address decoder top level: config registers, front, queue and back
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_word (address, is_write, is_word, data_in)
//   out      output     out_valid/out_stall out_word (region ... data_out)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while out_stall stays low; an accepted word is written into
// the queue, then into the result register, from which it is offered at the output
// reset (synchronous, rst_n low) empties the queue and the result register and loads
// the register defaults; cfg_ready is always high
// in_stall rises only when the queue holds two words, i.e. after out_stall has held
module bank_address_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bad_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bad_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  bad_pkg::cfg_t  cfg_r;
  bad_pkg::cfg_t  cfg_nxt;
  logic           push_valid;
  bad_pkg::item_t push_item;
  logic           queue_full;
  logic           pop;
  logic           head_valid;
  bad_pkg::item_t head_item;

  assign cfg_ready = 1'b1;
  assign in_stall  = queue_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (bad_pkg::cfg_index_t'(cfg_index))
        bad_pkg::CFG_CHIP_BANKS:    cfg_nxt.chip_banks    = cfg_data[5:0];
        bad_pkg::CFG_FAST_BANKS:    cfg_nxt.fast_banks    = cfg_data;
        bad_pkg::CFG_SLOW_BANKS:    cfg_nxt.slow_banks    = cfg_data[3:0];
        bad_pkg::CFG_CLOCK_ENABLED: cfg_nxt.clock_enabled = cfg_data[0];
        bad_pkg::CFG_OVERLAY_ON:    cfg_nxt.overlay_on    = cfg_data[0];
        bad_pkg::CFG_BOOT_PRESENT:  cfg_nxt.boot_present  = cfg_data[0];
        bad_pkg::CFG_KICK_PRESENT:  cfg_nxt.kick_present  = cfg_data[0];
        bad_pkg::CFG_KICK_WRITABLE: cfg_nxt.kick_writable = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{chip_banks: 6'd4, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bad_front u_front (
    .in_valid   (in_valid),
    .in_word    (in_word),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  bad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  bad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .chip_banks (cfg_r.chip_banks),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .out_stall  (out_stall)
  );

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the bank address decoder
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ACCESSES = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bad_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bad_pkg::out_word_t out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  bank_address_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copy as seen by the predictor, reset values first
  bad_pkg::cfg_t decoder_cfg = '{chip_banks: 6'd4, default: '0};

  bad_pkg::in_word_t  pending_accesses[$];
  bad_pkg::out_word_t expected_decodes[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned accesses_taken = 0;
  int unsigned results_seen = 0;
  int unsigned settings_count = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic [8:0]  regions_seen = '0;

  function automatic bad_pkg::region_t map_bank(logic [7:0] bank);
    int               fast_end;
    int               slow_end;
    bad_pkg::region_t kick_map;
    bad_pkg::region_t boot_map;
    fast_end = bad_pkg::BANK_FAST_FIRST +
               ((decoder_cfg.fast_banks > bad_pkg::FAST_MAX_BANKS) ?
                bad_pkg::FAST_MAX_BANKS : decoder_cfg.fast_banks);
    slow_end = bad_pkg::BANK_CUSTOM_FIRST +
               ((decoder_cfg.slow_banks > bad_pkg::SLOW_MAX_BANKS) ?
                bad_pkg::SLOW_MAX_BANKS : decoder_cfg.slow_banks);
    kick_map = decoder_cfg.kick_present ? bad_pkg::REGION_KICK : bad_pkg::REGION_UNMAPPED;
    boot_map = decoder_cfg.boot_present ? bad_pkg::REGION_BOOT : bad_pkg::REGION_UNMAPPED;
    if (bank < bad_pkg::BANK_FAST_FIRST) return bad_pkg::REGION_CHIP;
    if (bank < fast_end) return bad_pkg::REGION_FAST;
    if (bank >= bad_pkg::BANK_PERIPH_FIRST && bank <= bad_pkg::BANK_PERIPH_LAST)
      return bad_pkg::REGION_PERIPH;
    if (bank >= bad_pkg::BANK_CUSTOM_FIRST && bank <= bad_pkg::BANK_CUSTOM_LAST) begin
      if (bank < slow_end) return bad_pkg::REGION_SLOW;
      if (decoder_cfg.clock_enabled && bank >= bad_pkg::BANK_CLOCK_FIRST &&
          bank <= bad_pkg::BANK_CLOCK_LAST)
        return bad_pkg::REGION_CLOCK;
      return bad_pkg::REGION_CUSTOM;
    end
    if (bank >= bad_pkg::BANK_BOOT_FIRST && bank < bad_pkg::BANK_KICK_FIRST)
      return decoder_cfg.kick_writable ? boot_map : kick_map;
    if (bank >= bad_pkg::BANK_KICK_FIRST) return kick_map;
    return bad_pkg::REGION_UNMAPPED;
  endfunction

  // overlay walks the rom banks in order and falls back at the first hole
  function automatic bad_pkg::region_t bank_to_region(logic [7:0] bank);
    if (decoder_cfg.overlay_on && bank < 8) begin
      for (int i = 0; i <= int'(bank); i++)
        if (map_bank(8'(bad_pkg::BANK_BOOT_FIRST + i)) == bad_pkg::REGION_UNMAPPED)
          return map_bank(bank);
      return map_bank(8'(bad_pkg::BANK_BOOT_FIRST + bank));
    end
    return map_bank(bank);
  endfunction

  function automatic bad_pkg::out_word_t decode_access(bad_pkg::in_word_t acc);
    bad_pkg::out_word_t r;
    int unsigned        chip_size;
    r = '0;
    r.region = bank_to_region(acc.address[23:16]);
    chip_size = ((decoder_cfg.chip_banks == 0) ? 1 : decoder_cfg.chip_banks) * 32'h10000;
    case (r.region)
      bad_pkg::REGION_CHIP: r.offset = 23'(acc.address % chip_size);
      bad_pkg::REGION_FAST: r.offset = 23'(acc.address - bad_pkg::FAST_BASE);
      bad_pkg::REGION_SLOW: r.offset = 23'(acc.address[18:0]);
      bad_pkg::REGION_BOOT, bad_pkg::REGION_KICK: r.offset = 23'(acc.address[17:0]);
      bad_pkg::REGION_PERIPH: begin
        r.periph_a_select = !acc.address[12];
        r.periph_b_select = !acc.address[13];
        r.periph_register = acc.address[11:8];
      end
      bad_pkg::REGION_CUSTOM: r.custom_word_index = acc.address[8:1];
      default: ;
    endcase
    if (acc.is_write) begin
      r.forward_write = (r.region == bad_pkg::REGION_CHIP ||
                         r.region == bad_pkg::REGION_FAST ||
                         r.region == bad_pkg::REGION_PERIPH ||
                         r.region == bad_pkg::REGION_SLOW ||
                         r.region == bad_pkg::REGION_CUSTOM);
      if (r.forward_write) begin
        if (acc.is_word) r.data_out = acc.data_in;
        else if (r.region == bad_pkg::REGION_CUSTOM) r.data_out = {2{acc.data_in[7:0]}};
        else r.data_out = {8'h00, acc.data_in[7:0]};
      end
    end else if (r.region == bad_pkg::REGION_UNMAPPED ||
                 r.region == bad_pkg::REGION_CLOCK) begin
      r.constant_read = 1'b1;
      r.constant_value = (r.region == bad_pkg::REGION_CLOCK) && !acc.is_word;
    end
    return r;
  endfunction

  // pick banks near the region borders most of the time
  function automatic bad_pkg::in_word_t random_access();
    bad_pkg::in_word_t acc;
    logic [7:0]        bank;
    case ($urandom_range(7))
      0: bank = 8'($urandom_range(7));
      1: bank = 8'($urandom_range(8'h22, 8'h1E));
      2: bank = 8'(8'h1F + decoder_cfg.fast_banks + $urandom_range(2));
      3: bank = 8'($urandom_range(8'hC1, 8'h9E));
      4: bank = 8'(8'hBF + decoder_cfg.slow_banks + $urandom_range(2));
      5: bank = 8'($urandom_range(8'hDF, 8'hDB));
      6: bank = 8'($urandom_range(8'hFF, 8'hF6));
      default: bank = 8'($urandom);
    endcase
    acc.address = {bank, 16'($urandom)};
    acc.is_write = 1'($urandom);
    acc.is_word = 1'($urandom);
    acc.data_in = 16'($urandom);
    return acc;
  endfunction

  task automatic queue_access(logic [23:0] address, logic is_write, logic is_word,
                              logic [15:0] data_in);
    bad_pkg::in_word_t acc;
    acc.address = address;
    acc.is_write = is_write;
    acc.is_word = is_word;
    acc.data_in = data_in;
    pending_accesses.push_back(acc);
  endtask

  task automatic write_reg(bad_pkg::cfg_index_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bad_pkg::CFG_CHIP_BANKS:    decoder_cfg.chip_banks = value[5:0];
      bad_pkg::CFG_FAST_BANKS:    decoder_cfg.fast_banks = value;
      bad_pkg::CFG_SLOW_BANKS:    decoder_cfg.slow_banks = value[3:0];
      bad_pkg::CFG_CLOCK_ENABLED: decoder_cfg.clock_enabled = value[0];
      bad_pkg::CFG_OVERLAY_ON:    decoder_cfg.overlay_on = value[0];
      bad_pkg::CFG_BOOT_PRESENT:  decoder_cfg.boot_present = value[0];
      bad_pkg::CFG_KICK_PRESENT:  decoder_cfg.kick_present = value[0];
      bad_pkg::CFG_KICK_WRITABLE: decoder_cfg.kick_writable = value[0];
      default: ;
    endcase
  endtask

  // called on a rising edge with the block idle
  task automatic program_setting(logic [7:0] chip, logic [7:0] fast, logic [7:0] slow,
                                 logic [7:0] clk_en, logic [7:0] ovl, logic [7:0] boot,
                                 logic [7:0] kick, logic [7:0] kick_wr);
    write_reg(bad_pkg::CFG_CHIP_BANKS, chip);
    write_reg(bad_pkg::CFG_FAST_BANKS, fast);
    write_reg(bad_pkg::CFG_SLOW_BANKS, slow);
    write_reg(bad_pkg::CFG_CLOCK_ENABLED, clk_en);
    write_reg(bad_pkg::CFG_OVERLAY_ON, ovl);
    write_reg(bad_pkg::CFG_BOOT_PRESENT, boot);
    write_reg(bad_pkg::CFG_KICK_PRESENT, kick);
    write_reg(bad_pkg::CFG_KICK_WRITABLE, kick_wr);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // waits until every queued access has been sent and has come back, then lets the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (pending_accesses.size() > 0 || in_valid || expected_decodes.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_decodes.push_back(decode_access(in_word));
        accesses_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= pending_accesses.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk) begin : monitor
    bad_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_word.region <= bad_pkg::REGION_KICK) regions_seen[out_word.region] <= 1'b1;
        if (expected_decodes.size() == 0) begin
          $error("result word with no access outstanding");
          mismatches++;
        end else begin
          want = expected_decodes.pop_front();
          check_field("region", want.region, out_word.region);
          check_field("offset", want.offset, out_word.offset);
          check_field("forward_write", want.forward_write, out_word.forward_write);
          check_field("constant_read", want.constant_read, out_word.constant_read);
          check_field("constant_value", want.constant_value, out_word.constant_value);
          check_field("periph_a_select", want.periph_a_select, out_word.periph_a_select);
          check_field("periph_b_select", want.periph_b_select, out_word.periph_b_select);
          check_field("periph_register", want.periph_register, out_word.periph_register);
          check_field("custom_word_index", want.custom_word_index,
                      out_word.custom_word_index);
          check_field("data_out", want.data_out, out_word.data_out);
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset map: chip mirror, no fast ram, no roms
    @(negedge clk);
    queue_access(24'h000000, 1'b0, 1'b0, 16'h0000);
    queue_access(24'h1FFFFE, 1'b1, 1'b1, 16'hFFFF);
    queue_access(24'h050001, 1'b1, 1'b0, 16'hA55A);
    queue_access(24'h200000, 1'b1, 1'b1, 16'h1234);
    queue_access(24'hBFDFFF, 1'b0, 1'b0, 16'h0000);
    queue_access(24'hA0EF00, 1'b1, 1'b0, 16'h00C3);
    queue_access(24'hDFF1FE, 1'b1, 1'b0, 16'h7E81);
    queue_access(24'hC00001, 1'b1, 1'b1, 16'hBEEF);
    queue_access(24'hFFFFFF, 1'b0, 1'b0, 16'hFFFF);
    queue_access(24'hF80000, 1'b1, 1'b1, 16'h5555);
    drain();

    // zero chip size, oversized fast and slow, everything enabled
    program_setting(8'h00, 8'hFF, 8'h0F, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
    @(negedge clk);
    queue_access(24'h123456, 1'b1, 1'b1, 16'h0F0F);
    queue_access(24'h9FFFFF, 1'b1, 1'b0, 16'hFF80);
    queue_access(24'hA00000, 1'b1, 1'b1, 16'h8001);
    queue_access(24'hC7FFFF, 1'b0, 1'b0, 16'h0000);
    queue_access(24'hC80000, 1'b1, 1'b0, 16'h00FF);
    queue_access(24'hDC0001, 1'b0, 1'b0, 16'h0000);
    queue_access(24'hDE0000, 1'b0, 1'b1, 16'h0000);
    queue_access(24'hDD0000, 1'b1, 1'b1, 16'hCAFE);
    queue_access(24'h000010, 1'b0, 1'b1, 16'h0000);
    queue_access(24'h070000, 1'b1, 1'b0, 16'h0001);
    queue_access(24'hE00000, 1'b0, 1'b1, 16'h0000);
    queue_access(24'hFC1234, 1'b1, 1'b0, 16'h4321);
    queue_access(24'hF80000, 1'b0, 1'b0, 16'h0000);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)
        program_setting(8'd32, 8'd128, 8'd8, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00);
      else if (ph == 1)
        program_setting(8'd1, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      else
        program_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      @(negedge clk);
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 56 : (mode == 3) ? 7 : 0;
      recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 7 : 0;
      repeat (PHASE_ACCESSES) pending_accesses.push_back(random_access());
      // long receiver hold-off while the sender keeps offering words
      if (ph == 0) hold_seq++;
      drain();
    end

    $display("decoded %0d accesses under %0d register settings, %0d results compared",
             accesses_taken, settings_count, results_seen);
    $display("%0d of 9 regions reached, %0d mismatches", $countones(regions_seen),
             mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
